[rtl/tsft_pkg.sv]
// Shared types and constants for the tilt state feedback torque block.
package tsft_pkg;

  localparam int DataWidth = 16;
  localparam int CfgIndexWidth = 3;
  localparam int CordicMaxIter = 24;
  localparam int CordicIterDefault = 16;
  localparam int AngleWidth = 34;
  localparam int CordicWidth = 40;

  typedef enum logic [1:0] {
    OP_IMU   = 2'd0,
    OP_WHEEL = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_GAIN_PITCH      = 3'd0,
    REG_GAIN_PITCH_RATE = 3'd1,
    REG_GAIN_WHEEL      = 3'd2,
    REG_TORQUE_CONST    = 3'd3,
    REG_RESISTANCE      = 3'd4
  } reg_index_t;

  localparam logic signed [15:0] HalfPi = 16'sd12868;

  function automatic logic [AngleWidth-1:0] atan_entry(input logic [4:0] i);
    logic [AngleWidth-1:0] v;
    case (i)
      5'd0: v = 34'd843314856;
      5'd1: v = 34'd497837829;
      5'd2: v = 34'd263043836;
      5'd3: v = 34'd133525158;
      5'd4: v = 34'd67021686;
      5'd5: v = 34'd33543515;
      5'd6: v = 34'd16775850;
      5'd7: v = 34'd8388437;
      5'd8: v = 34'd4194282;
      5'd9: v = 34'd2097149;
      5'd10: v = 34'd1048575;
      5'd11: v = 34'd524287;
      5'd12: v = 34'd262143;
      5'd13: v = 34'd131071;
      5'd14: v = 34'd65535;
      5'd15: v = 34'd32767;
      5'd16: v = 34'd16383;
      5'd17: v = 34'd8191;
      5'd18: v = 34'd4095;
      5'd19: v = 34'd2047;
      5'd20: v = 34'd1023;
      5'd21: v = 34'd511;
      5'd22: v = 34'd255;
      5'd23: v = 34'd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/tsft_if.sv]
// Valid/ready channel interfaces for requests and results.
interface tsft_req_if;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_pitch_rate;
  logic signed [15:0] wheel_speed_right;
  logic signed [15:0] wheel_speed_left;
  modport source (output valid, opcode, accel_x, accel_y, accel_z, gyro_pitch_rate,
                  wheel_speed_right, wheel_speed_left, input ready);
  modport sink (input valid, opcode, accel_x, accel_y, accel_z, gyro_pitch_rate,
                wheel_speed_right, wheel_speed_left, output ready);
endinterface

interface tsft_res_if;
  logic valid;
  logic ready;
  logic signed [15:0] torque_command;
  logic signed [15:0] pitch_angle;
  logic saturated;
  modport source (output valid, torque_command, pitch_angle, saturated, input ready);
  modport sink (input valid, torque_command, pitch_angle, saturated, output ready);
endinterface

[rtl/tsft_seq.sv]
// Sequencer and shared datapath: isqrt, CORDIC, multiplies and restoring divide.
module tsft_seq #(
  parameter int CordicIterations = tsft_pkg::CordicIterDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [1:0] opcode,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_pitch_rate,
  input  logic signed [15:0] wheel_speed_right,
  input  logic signed [15:0] wheel_speed_left,
  input  logic signed [15:0] gain_pitch,
  input  logic signed [15:0] gain_pitch_rate,
  input  logic signed [15:0] gain_wheel_speed,
  input  logic [15:0] motor_torque_constant,
  input  logic [15:0] motor_resistance,
  output logic busy,
  output logic done,
  output logic signed [15:0] torque_command,
  output logic signed [15:0] pitch_angle,
  output logic saturated
);
  localparam int CW = tsft_pkg::CordicWidth;
  localparam int AW = tsft_pkg::AngleWidth;
  localparam int NIter = (CordicIterations > tsft_pkg::CordicMaxIter) ?
                         tsft_pkg::CordicMaxIter : CordicIterations;
  localparam logic [4:0] LastIter = 5'(NIter - 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SQ    = 12'b000000000010,
    S_SQRT  = 12'b000000000100,
    S_CINIT = 12'b000000001000,
    S_CORD  = 12'b000000010000,
    S_ANG   = 12'b000000100000,
    S_M1    = 12'b000001000000,
    S_M2    = 12'b000010000000,
    S_M3    = 12'b000100000000,
    S_M4    = 12'b001000000000,
    S_KMUL  = 12'b010000000000,
    S_DIV   = 12'b100000000000
  } state_t;

  state_t state;
  logic [5:0] cnt;
  logic signed [15:0] ax, ay, az;
  logic [33:0] radicand;
  logic [16:0] root;
  logic signed [CW-1:0] cx, cy;
  logic signed [AW-1:0] cz;
  logic signed [15:0] pitch_rate_q, wheel_q;
  logic signed [31:0] prod;
  logic signed [40:0] vacc;
  logic [39:0] vmag;
  logic [56:0] dividend;
  logic [56:0] dquo;
  logic [29:0] drem;
  logic neg;

  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] mul_p;
  logic signed [CW-1:0] dx, dy;
  logic signed [AW-1:0] zr;
  logic [29:0] divisor;
  logic [30:0] dtry;
  logic [29:0] rem_sh;
  logic [35:0] sqrt_rem_next;
  logic [35:0] sqrt_try;
  logic [56:0] qfin;
  logic signed [57:0] qs;

  // single shared 16x16 multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_IDLE: begin
        mul_a = gain_pitch;
        mul_b = pitch_angle;
      end
      S_SQ: begin
        if (cnt == 6'd0) begin
          mul_a = ay;
          mul_b = ay;
        end else begin
          mul_a = az;
          mul_b = az;
        end
      end
      S_M1: begin
        mul_a = gain_pitch_rate;
        mul_b = pitch_rate_q;
      end
      S_M2: begin
        mul_a = gain_wheel_speed;
        mul_b = wheel_q;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DIV) &&
                ((cnt == 6'd0 && motor_resistance == 16'd0) || cnt == 6'd57);
  assign divisor = {1'b0, motor_resistance, 13'd0};
  assign rem_sh = {drem[28:0], dividend[56]};
  assign dtry = {1'b0, rem_sh} - {1'b0, divisor};
  assign dx = cy >>> cnt[4:0];
  assign dy = cx >>> cnt[4:0];
  assign zr = (cz + AW'(65536)) >>> 17;

  // restoring sqrt, two bits per step, 17 steps
  assign sqrt_rem_next = {vacc[33:0], radicand[33:32]};
  assign sqrt_try = sqrt_rem_next - {17'd0, root, 2'b01};

  // last divide step
  assign qfin = !dtry[30] ? {dquo[55:0], 1'b1} : {dquo[55:0], 1'b0};
  assign qs = neg ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pitch_angle <= '0;
      pitch_rate_q <= '0;
      wheel_q <= '0;
      cnt <= '0;
      torque_command <= '0;
      saturated <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            ax <= accel_x;
            ay <= accel_y;
            az <= accel_z;
            cnt <= '0;
            case (opcode)
              tsft_pkg::OP_IMU: begin
                pitch_rate_q <= gyro_pitch_rate;
                state <= S_SQ;
              end
              tsft_pkg::OP_WHEEL: begin
                wheel_q <= 16'((17'(wheel_speed_right) + 17'(wheel_speed_left)) >>> 1);
              end
              tsft_pkg::OP_TICK: begin
                prod <= mul_p;
                state <= S_M1;
              end
              default: ;
            endcase
          end
        end
        S_SQ: begin
          if (cnt == 6'd0) begin
            prod <= mul_p;
            cnt <= 6'd1;
          end else begin
            radicand <= {2'b00, prod} + {2'b00, mul_p};
            vacc <= '0;
            root <= '0;
            cnt <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          radicand <= radicand << 2;
          if (!sqrt_try[35]) begin
            vacc <= 41'(sqrt_try);
            root <= {root[15:0], 1'b1};
          end else begin
            vacc <= 41'(sqrt_rem_next);
            root <= {root[15:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd16) state <= S_CINIT;
        end
        S_CINIT: begin
          cnt <= '0;
          if (root == '0) begin
            if (ax == 16'sd0) pitch_angle <= '0;
            else if (ax < 0) pitch_angle <= tsft_pkg::HalfPi;
            else pitch_angle <= -tsft_pkg::HalfPi;
            state <= S_IDLE;
          end else begin
            cx <= CW'(root) <<< 14;
            cy <= -(CW'(ax) <<< 14);
            cz <= '0;
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (!cy[CW-1]) begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + AW'(tsft_pkg::atan_entry(cnt[4:0]));
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - AW'(tsft_pkg::atan_entry(cnt[4:0]));
          end
          if (cnt[4:0] == LastIter) begin
            cnt <= '0;
            state <= S_ANG;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_ANG: begin
          if (zr > AW'(32767)) pitch_angle <= 16'sd32767;
          else if (zr < -AW'(32768)) pitch_angle <= -16'sd32768;
          else pitch_angle <= 16'(zr);
          state <= S_IDLE;
        end
        S_M1: begin
          vacc <= 41'(prod);
          prod <= mul_p;
          state <= S_M2;
        end
        S_M2: begin
          vacc <= vacc + (41'(prod) <<< 5);
          prod <= mul_p;
          state <= S_M3;
        end
        S_M3: begin
          vacc <= vacc + (41'(prod) <<< 5);
          state <= S_M4;
        end
        S_M4: begin
          neg <= vacc[40];
          vmag <= vacc[40] ? 40'(-vacc) : 40'(vacc);
          dividend <= '0;
          cnt <= '0;
          state <= S_KMUL;
        end
        // shift-and-add multiply of |V| by the torque constant, MSB first
        S_KMUL: begin
          dividend <= (dividend << 1) +
                      (motor_torque_constant[4'd15 - cnt[3:0]] ? 57'(vmag) : 57'd0);
          if (cnt == 6'd15) begin
            cnt <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DIV: begin
          if (cnt == 6'd0) begin
            drem <= '0;
            dquo <= '0;
            if (motor_resistance == 16'd0) begin
              saturated <= 1'b1;
              torque_command <= (dividend == '0) ? 16'sd0 :
                                (neg ? -16'sd32768 : 16'sd32767);
              state <= S_IDLE;
            end else begin
              cnt <= 6'd1;
            end
          end else begin
            dividend <= dividend << 1;
            if (!dtry[30]) begin
              drem <= dtry[29:0];
              dquo <= {dquo[55:0], 1'b1};
            end else begin
              drem <= rem_sh;
              dquo <= {dquo[55:0], 1'b0};
            end
            if (cnt == 6'd57) begin
              cnt <= '0;
              state <= S_IDLE;
              if (qs > 58'sd32767) begin
                torque_command <= 16'sd32767;
                saturated <= 1'b1;
              end else if (qs < -58'sd32768) begin
                torque_command <= -16'sd32768;
                saturated <= 1'b1;
              end else begin
                torque_command <= 16'(qs);
                saturated <= 1'b0;
              end
            end else begin
              cnt <= cnt + 6'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/tilt_state_feedback_torque.sv]
// Top level of the tilt state feedback torque controller.
// One request at a time; ready is low while a request is in work or a result waits.
// An IMU request, once accepted, runs through the squaring of accel_y and accel_z,
// a 17-step square root, a setup step, one CORDIC step per cycle and a rounding
// step; the CORDIC and rounding steps are skipped when accel_y and accel_z are both
// zero. A wheel request is handled in its accept cycle. A control tick runs through
// the gain products and their sum, a shift-and-add multiply by the torque constant,
// a divider setup step and 57 divide steps at one quotient bit per cycle; with
// zero resistance the setup step gives a saturated result without dividing.
// Results appear only for control ticks and are held in an output register until
// taken; the next request is accepted no earlier than the cycle after that.
module tilt_state_feedback_torque #(
  parameter int CORDIC_ITERATIONS = tsft_pkg::CordicIterDefault
) (
  input  logic clk,
  input  logic rst,
  tsft_req_if.sink req,
  tsft_res_if.source res,
  input  logic cfg_we,
  input  logic [tsft_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [tsft_pkg::DataWidth-1:0] cfg_data
);
  logic signed [15:0] gain_pitch, gain_pitch_rate, gain_wheel_speed;
  logic [15:0] motor_torque_constant, motor_resistance;
  logic busy, done, sat;
  logic signed [15:0] torque, pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_pitch <= '0;
      gain_pitch_rate <= '0;
      gain_wheel_speed <= '0;
      motor_torque_constant <= 16'd256;
      motor_resistance <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        tsft_pkg::REG_GAIN_PITCH: gain_pitch <= cfg_data;
        tsft_pkg::REG_GAIN_PITCH_RATE: gain_pitch_rate <= cfg_data;
        tsft_pkg::REG_GAIN_WHEEL: gain_wheel_speed <= cfg_data;
        tsft_pkg::REG_TORQUE_CONST: motor_torque_constant <= cfg_data;
        tsft_pkg::REG_RESISTANCE: motor_resistance <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req.ready = !busy && !res.valid;

  tsft_seq #(.CordicIterations(CORDIC_ITERATIONS)) u_seq (
    .clk(clk), .rst(rst), .start(req.valid && req.ready), .opcode(req.opcode),
    .accel_x(req.accel_x), .accel_y(req.accel_y), .accel_z(req.accel_z),
    .gyro_pitch_rate(req.gyro_pitch_rate), .wheel_speed_right(req.wheel_speed_right),
    .wheel_speed_left(req.wheel_speed_left), .gain_pitch(gain_pitch),
    .gain_pitch_rate(gain_pitch_rate), .gain_wheel_speed(gain_wheel_speed),
    .motor_torque_constant(motor_torque_constant), .motor_resistance(motor_resistance),
    .busy(busy), .done(done), .torque_command(torque), .pitch_angle(pitch),
    .saturated(sat)
  );

  // done marks the edge at which the result registers are written
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      if (done) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
    end
  end

  assign res.torque_command = torque;
  assign res.pitch_angle = pitch;
  assign res.saturated = sat;
endmodule
